>>> rtl/core/cidt_pkg.sv
// Shared constants, codes and types of the card ID allowlist table.
package cidt_pkg;

  // Table geometry and field widths.
  localparam int MAX_CARDS = 32;
  localparam int ID_W      = 32;
  localparam int OP_W      = 2;
  localparam int SLOT_W    = 5;
  localparam int COUNT_W   = 6;
  localparam int IDX_W     = (MAX_CARDS > 1) ? $clog2(MAX_CARDS) : 1;
  localparam int CNT_W     = IDX_W + 1;

  // Operation codes; the unused code behaves as a lookup.
  typedef enum logic [OP_W-1:0] {
    OP_LOOKUP = 2'd0,
    OP_ADD    = 2'd1,
    OP_DELETE = 2'd2
  } op_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_UPDATE
  } state_t;

  // What every cell does in a given cycle.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_ROTATE,
    CELL_COMPACT,
    CELL_LOAD
  } cell_mode_t;

  // Command broadcast from the controller to the row of cells.
  typedef struct packed {
    cell_mode_t        mode;
    logic [IDX_W-1:0]  slot;
    logic [CNT_W-1:0]  count;
    logic [ID_W-1:0]   id;
  } cell_cmd_t;

  // One result item.
  typedef struct packed {
    logic               is_master;
    logic               master_present;
    logic               found;
    logic [SLOT_W-1:0]  slot_index;
    logic               accepted;
    logic               table_full;
    logic [COUNT_W-1:0] card_count;
  } result_t;

endpackage

>>> rtl/core/card_id_allowlist_table.sv
// Top level of the card ID allowlist table: controller and a ring of table cells.
//
// A request on the in_ channel carries an operation (lookup, add, delete) and a
// 32-bit card ID. It is taken when in_valid and in_ready are both high; in_ready is
// high only while no request is being worked on. Each request yields one result on
// the out_ channel, taken when out_valid and out_ready are both high.
// The table is a ring of MAX_CARDS cells. A request first turns the ring once,
// one slot per cycle, comparing the head cell with the ID, then applies the add
// or delete and writes the result register once that register is free. in_ready is
// high again in the cycle in which out_valid rises.
// A result waiting on a stalled receiver does not block the next request; the
// next update waits in place until the result register has been emptied.
// The master ID is written through cfg_we and cfg_wdata while the block is idle;
// the user must keep to this, as the block itself does not enforce it.
// Reset (rst_n low, synchronous) empties the table and clears the master ID;
// no clearing pass is needed because slots above the count are never read.
module card_id_allowlist_table (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [cidt_pkg::OP_W-1:0]     in_operation,
  input  logic [cidt_pkg::ID_W-1:0]     in_card_id,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_is_master,
  output logic                          out_master_present,
  output logic                          out_found,
  output logic [cidt_pkg::SLOT_W-1:0]   out_slot_index,
  output logic                          out_accepted,
  output logic                          out_table_full,
  output logic [cidt_pkg::COUNT_W-1:0]  out_card_count,
  input  logic                          cfg_we,
  input  logic [cidt_pkg::ID_W-1:0]     cfg_wdata
);
  import cidt_pkg::*;

  cell_cmd_t       cell_cmd;
  result_t         result;
  logic [ID_W-1:0] entry [MAX_CARDS];

  // Sequencer.
  cidt_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .in_card_id   (in_card_id),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .head_entry   (entry[0]),
    .cell_cmd     (cell_cmd),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result       (result)
  );

  // Ring of cells: each takes the entry of the next slot, the last wraps to slot zero.
  for (genvar k = 0; k < MAX_CARDS; k++) begin : g_cell
    logic [ID_W-1:0] next_entry;
    if (k == MAX_CARDS - 1) begin : g_wrap
      assign next_entry = entry[0];
    end else begin : g_link
      assign next_entry = entry[k + 1];
    end
    cidt_cell u_cell (
      .clk        (clk),
      .cmd        (cell_cmd),
      .cell_idx   (IDX_W'(k)),
      .next_entry (next_entry),
      .entry      (entry[k])
    );
  end

  assign out_is_master      = result.is_master;
  assign out_master_present = result.master_present;
  assign out_found          = result.found;
  assign out_slot_index     = result.slot_index;
  assign out_accepted       = result.accepted;
  assign out_table_full     = result.table_full;
  assign out_card_count     = result.card_count;

endmodule

>>> rtl/core/cidt_cell.sv
// One slot of the ID table: holds an entry and takes its neighbor's entry on command.
module cidt_cell (
  input  logic                          clk,
  input  cidt_pkg::cell_cmd_t           cmd,
  input  logic [cidt_pkg::IDX_W-1:0]    cell_idx,
  input  logic [cidt_pkg::ID_W-1:0]     next_entry,
  output logic [cidt_pkg::ID_W-1:0]     entry
);
  import cidt_pkg::*;

  logic [ID_W-1:0] entry_r;
  logic [ID_W-1:0] entry_nxt;

  // Rotate with the whole row, close the gap above a deleted slot, or take a new ID.
  always_comb begin
    entry_nxt = entry_r;
    case (cmd.mode)
      CELL_HOLD:    entry_nxt = entry_r;
      CELL_ROTATE:  entry_nxt = next_entry;
      CELL_COMPACT: begin
        if (cell_idx >= cmd.slot) begin
          entry_nxt = next_entry;
        end
      end
      CELL_LOAD: begin
        if (CNT_W'(cell_idx) == cmd.count) begin
          entry_nxt = cmd.id;
        end
      end
      default:      entry_nxt = entry_r;
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

>>> rtl/core/cidt_ctrl.sv
// Sequencer of the ID table: request handshakes, serial search, update and result register.
module cidt_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [cidt_pkg::OP_W-1:0]   in_operation,
  input  logic [cidt_pkg::ID_W-1:0]   in_card_id,
  input  logic                        cfg_we,
  input  logic [cidt_pkg::ID_W-1:0]   cfg_wdata,
  input  logic [cidt_pkg::ID_W-1:0]   head_entry,
  output cidt_pkg::cell_cmd_t         cell_cmd,
  output logic                        out_valid,
  input  logic                        out_ready,
  output cidt_pkg::result_t           result
);
  import cidt_pkg::*;

  state_t           state_r,     state_nxt;
  logic [CNT_W-1:0] step_r,      step_nxt;
  logic [OP_W-1:0]  op_r,        op_nxt;
  logic [ID_W-1:0]  id_r,        id_nxt;
  logic             found_r,     found_nxt;
  logic [IDX_W-1:0] slot_r,      slot_nxt;
  logic [CNT_W-1:0] count_r,     count_nxt;
  logic [ID_W-1:0]  master_r,    master_nxt;
  logic             out_valid_r, out_valid_nxt;
  result_t          res_r,       res_nxt;

  logic             accepted;
  logic             full;

  // Next state, cell command and result.
  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    op_nxt        = op_r;
    id_nxt        = id_r;
    found_nxt     = found_r;
    slot_nxt      = slot_r;
    count_nxt     = count_r;
    master_nxt    = cfg_we ? cfg_wdata : master_r;
    out_valid_nxt = out_valid_r && !out_ready;
    res_nxt       = res_r;
    in_ready      = 1'b0;
    accepted      = 1'b0;
    full          = 1'b0;

    cell_cmd.mode  = CELL_HOLD;
    cell_cmd.slot  = slot_r;
    cell_cmd.count = count_r;
    cell_cmd.id    = id_r;

    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op_nxt    = in_operation;
          id_nxt    = in_card_id;
          found_nxt = 1'b0;
          slot_nxt  = '0;
          step_nxt  = '0;
          state_nxt = ST_SEARCH;
        end
      end

      // The row rotates once per cycle; the head entry is compared against the request.
      // After a full turn every entry is back in its own slot.
      ST_SEARCH: begin
        cell_cmd.mode = CELL_ROTATE;
        if ((step_r < count_r) && (head_entry == id_r) && !found_r) begin
          found_nxt = 1'b1;
          slot_nxt  = step_r[IDX_W-1:0];
        end
        if (step_r == CNT_W'(MAX_CARDS - 1)) begin
          state_nxt = ST_UPDATE;
        end else begin
          step_nxt = step_r + CNT_W'(1);
        end
      end

      // Apply the add or delete once the result register is free.
      ST_UPDATE: begin
        if (!out_valid_r || out_ready) begin
          if (op_r == OP_ADD) begin
            if (!found_r) begin
              if (count_r == CNT_W'(MAX_CARDS)) begin
                full = 1'b1;
              end else begin
                cell_cmd.mode = CELL_LOAD;
                count_nxt     = count_r + CNT_W'(1);
                accepted      = 1'b1;
              end
            end
          end else if (op_r == OP_DELETE) begin
            if (found_r) begin
              cell_cmd.mode = CELL_COMPACT;
              count_nxt     = count_r - CNT_W'(1);
              accepted      = 1'b1;
            end
          end
          res_nxt.is_master      = (id_r == master_r);
          res_nxt.master_present = (master_r != '0);
          res_nxt.found          = found_r;
          res_nxt.slot_index     = found_r ? SLOT_W'(slot_r) : '0;
          res_nxt.accepted       = accepted;
          res_nxt.table_full     = full;
          res_nxt.card_count     = COUNT_W'(count_nxt);
          out_valid_nxt          = 1'b1;
          state_nxt              = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      master_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      master_r    <= master_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Request and result payload registers.
  always_ff @(posedge clk) begin
    step_r  <= step_nxt;
    op_r    <= op_nxt;
    id_r    <= id_nxt;
    found_r <= found_nxt;
    slot_r  <= slot_nxt;
    res_r   <= res_nxt;
  end

  assign out_valid = out_valid_r;
  assign result    = res_r;

endmodule
